// ===== design/merge_sort_engine_assert.svh =====
// Assertion macros shared by the merge sort engine checker.
// No dependencies; guarded against double inclusion.
`ifndef MERGE_SORT_ENGINE_ASSERT_SVH
`define MERGE_SORT_ENGINE_ASSERT_SVH
// Implication checked on every edge outside reset.
`define MSE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define MSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== design/mse_pkg.sv =====
// Shared types and constants for the merge sort engine.
// No dependencies.
`default_nettype none
package mse_pkg;
   localparam int Depth = 64;
   localparam int AddrW = $clog2(Depth);
   localparam int CntW = AddrW + 1;
   localparam int QDepth = 2;

   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_res;
      logic               last_res;
      logic               overflow;
   } rsp_type;

   // Classified item handed from front to back.
   typedef struct packed {
      logic        keep;
      logic        last;
      logic [31:0] value;
   } cmd_type;
endpackage
`default_nettype wire

// ===== design/merge_sort_engine.sv =====
// Merge sort engine top level: front end, queue, merge back end.
// Depends on mse_pkg, mse_front, mse_queue, mse_back.
// Values stream in one beat a cycle while the back end is loading; a beat
// with last set closes the set. The back end then runs bottom-up merge
// passes between two RAMs; each merge step reads both run heads in turn
// through the single RAM read port before it writes one of them, and each
// sorted value is read back from RAM before it is emitted. Input stalls
// while the set is sorted and emitted. Beyond 64 values the surplus is
// dropped and flagged on the final result.
`default_nettype none
module merge_sort_engine import mse_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
   logic    f_valid, f_ready, b_valid, b_ready;
   cmd_type f_data, b_data;

   mse_front u_front (.clock, .reset, .req_valid, .req_ready, .req_data,
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_data));
   mse_queue u_queue (.clock, .reset, .in_valid(f_valid), .in_ready(f_ready),
      .in_data(f_data), .out_valid(b_valid), .out_ready(b_ready),
      .out_data(b_data));
   mse_back u_back (.clock, .reset, .cmd_valid(b_valid), .cmd_ready(b_ready),
      .cmd_data(b_data), .rsp_valid, .rsp_ready, .rsp_data);
endmodule
`default_nettype wire

// ===== design/mse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mse_ram #(
   parameter int Width = 32,
   parameter int Size = 64
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [$clog2(Size)-1:0] wr_addr,
   input  wire logic [Width-1:0]        wr_data,
   input  wire logic [$clog2(Size)-1:0] rd_addr,
   output logic      [Width-1:0]        rd_data
);
   logic [Width-1:0] mem [Size];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== design/mse_front.sv =====
// Front end: accepts input beats, tracks fill level, flags dropped values.
// Depends on mse_pkg; feeds a short queue towards mse_back.
`default_nettype none
module mse_front import mse_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         cmd_valid,
   input  wire logic    cmd_ready,
   output cmd_type      cmd_data
);
   logic [CntW-1:0] count_ff, count_in;
   logic            full;

   assign full      = (count_ff == CntW'(Depth));
   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign cmd_data  = '{keep: !full, last: req_data.last, value: req_data.value};

   always_comb begin
      count_in = count_ff;
      if (req_valid && cmd_ready) begin
         if (req_data.last) count_in = '0;
         else if (!full)    count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end
endmodule
`default_nettype wire

// ===== design/mse_queue.sv =====
// Two-entry queue between front and back.
// Depends on mse_pkg.
`default_nettype none
module mse_queue import mse_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire cmd_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output cmd_type      out_data
);
   cmd_type     slot_ff [QDepth];
   logic        wp_ff, rp_ff;
   logic [1:0]  cnt_ff;
   logic        push, pop;

   assign in_ready  = (cnt_ff != 2'(QDepth));
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = slot_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= in_data;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule
`default_nettype wire

// ===== design/mse_back.sv =====
// Back end: stores values, runs bottom-up merge passes between two RAMs,
// then streams the sorted set. Depends on mse_pkg and mse_ram.
`default_nettype none
module mse_back import mse_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   output logic         cmd_ready,
   input  wire cmd_type cmd_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
   typedef enum logic [6:0] {
      S_LOAD  = 7'b0000001,
      S_PASS  = 7'b0000010,
      S_RDA   = 7'b0000100,
      S_CMP   = 7'b0001000,
      S_EMRD  = 7'b0010000,
      S_EMWT  = 7'b0100000,
      S_EMOUT = 7'b1000000
   } state_type;

   state_type       state_ff, state_in;
   logic [CntW-1:0] n_ff, n_in;
   logic            drop_ff, drop_in;
   logic [CntW:0]   width_ff, width_in;   // run width
   logic [CntW:0]   lo_ff, lo_in;
   logic [CntW:0]   i_ff, i_in, j_ff, j_in, mid_ff, mid_in, hi_ff, hi_in;
   logic [CntW-1:0] k_ff, k_in;           // write / emit index
   logic            src_ff, src_in;       // RAM holding current data
   logic            phase_ff, phase_in;   // reading i (0) or j (1)
   logic [31:0]     a_ff, a_in;
   rsp_type         out_ff, out_in;
   logic            ov_ff, ov_in;

   logic [AddrW-1:0] rd_addr, wr_addr;
   logic [31:0]      wr_data, rd0, rd1, rd;
   logic             we0, we1, we;
   logic             take_i;
   logic [CntW:0]    mid_c, hi_c;

   assign rd = src_ff ? rd1 : rd0;
   assign we0 = we && (state_ff == S_LOAD ? 1'b1 : src_ff);
   assign we1 = we && state_ff != S_LOAD && !src_ff;

   mse_ram #(.Width(32), .Size(Depth)) u_ram0 (
      .clock, .wr_en(we0), .wr_addr, .wr_data, .rd_addr, .rd_data(rd0));
   mse_ram #(.Width(32), .Size(Depth)) u_ram1 (
      .clock, .wr_en(we1), .wr_addr, .wr_data, .rd_addr, .rd_data(rd1));

   assign cmd_ready = (state_ff == S_LOAD);
   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;
   assign mid_c = lo_ff + width_ff;
   assign hi_c  = (mid_c + width_ff > (CntW+1)'(n_ff)) ? (CntW+1)'(n_ff)
                                                       : mid_c + width_ff;
   // Right run wins ties; exhausted runs drain the other.
   assign take_i = (i_ff < mid_ff) &&
                   ((j_ff >= hi_ff) || ($signed(a_ff) < $signed(rd)));

   always_comb begin
      state_in = state_ff; n_in = n_ff; drop_in = drop_ff;
      width_in = width_ff; lo_in = lo_ff; i_in = i_ff; j_in = j_ff;
      mid_in = mid_ff; hi_in = hi_ff; k_in = k_ff; src_in = src_ff;
      phase_in = phase_ff; a_in = a_ff; out_in = out_ff; ov_in = ov_ff;
      we = 1'b0; wr_addr = n_ff[AddrW-1:0]; wr_data = cmd_data.value;
      rd_addr = i_ff[AddrW-1:0];
      if (rsp_valid && rsp_ready) ov_in = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            if (cmd_valid) begin
               if (cmd_data.keep) begin
                  we = 1'b1;
                  n_in = n_ff + 1'b1;
               end else drop_in = 1'b1;
               if (cmd_data.last) begin
                  src_in = 1'b0; width_in = (CntW+1)'(1); lo_in = '0;
                  state_in = S_PASS;
               end
            end
         end
         S_PASS: begin
            // Start the next merge of a run pair, or the next pass.
            if ((CntW+1)'(n_ff) <= width_ff) begin
               k_in = '0; state_in = S_EMRD;
            end else if (mid_c >= (CntW+1)'(n_ff)) begin
               // Odd tail with no partner: copy it through as one run.
               if (lo_ff < (CntW+1)'(n_ff)) begin
                  mid_in = (CntW+1)'(n_ff); hi_in = (CntW+1)'(n_ff);
                  i_in = lo_ff; j_in = (CntW+1)'(n_ff);
                  k_in = lo_ff[CntW-1:0]; phase_in = 1'b0; state_in = S_RDA;
               end else begin
                  src_in = !src_ff; width_in = width_ff << 1; lo_in = '0;
               end
            end else begin
               mid_in = mid_c; hi_in = hi_c; i_in = lo_ff; j_in = mid_c;
               k_in = lo_ff[CntW-1:0]; phase_in = 1'b0; state_in = S_RDA;
            end
         end
         S_RDA: begin
            // Fetch the left head into a_ff, then the right head from RAM.
            if (!phase_ff) begin
               rd_addr = i_ff[AddrW-1:0]; phase_in = 1'b1;
            end else begin
               a_in = rd; rd_addr = j_ff[AddrW-1:0];
               phase_in = 1'b0; state_in = S_CMP;
            end
         end
         S_CMP: begin
            we = 1'b1; wr_addr = k_ff[AddrW-1:0];
            wr_data = take_i ? a_ff : rd;
            k_in = k_ff + 1'b1;
            if (take_i) i_in = i_ff + 1'b1;
            else        j_in = j_ff + 1'b1;
            if ((CntW+1)'(k_ff) + 1'b1 == hi_ff) begin
               lo_in = hi_ff; state_in = S_PASS;
            end else state_in = S_RDA;
         end
         S_EMRD: begin
            rd_addr = k_ff[AddrW-1:0];
            if (!ov_ff || rsp_ready) state_in = S_EMWT;
            if (n_ff == '0) begin
               state_in = S_LOAD; drop_in = 1'b0;
            end
         end
         S_EMWT: begin
            rd_addr = k_ff[AddrW-1:0];
            state_in = S_EMOUT;
         end
         S_EMOUT: begin
            if (!ov_ff || rsp_ready) begin
               out_in.value_res = rd;
               out_in.last_res = (k_ff + 1'b1 == n_ff);
               out_in.overflow = (k_ff + 1'b1 == n_ff) && drop_ff;
               ov_in = 1'b1;
               k_in = k_ff + 1'b1;
               if (k_ff + 1'b1 == n_ff) begin
                  n_in = '0; drop_in = 1'b0; state_in = S_LOAD;
               end else state_in = S_EMRD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      width_ff <= width_in; lo_ff <= lo_in; i_ff <= i_in; j_ff <= j_in;
      mid_ff <= mid_in; hi_ff <= hi_in; k_ff <= k_in; phase_ff <= phase_in;
      a_ff <= a_in; out_ff <= out_in; src_ff <= src_in;
      if (reset) begin
         state_ff <= S_LOAD; n_ff <= '0; drop_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; n_ff <= n_in; drop_ff <= drop_in; ov_ff <= ov_in;
      end
   end
endmodule
`default_nettype wire

// ===== design/mse_checker.sv =====
// Port-level checker for merge_sort_engine, bound to the top level.
// Depends on mse_pkg and merge_sort_engine_assert.svh.
`default_nettype none
`include "merge_sort_engine_assert.svh"
module mse_checker import mse_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);
   `MSE_ASSERT_IMPLY(a_ovf_final, clock, reset, rsp_valid && rsp_data.overflow,
      rsp_data.last_res)
   `MSE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data))
   `MSE_ASSERT_NEXT(a_no_rsp_after_reset, clock, 1'b0, reset, !rsp_valid)
   `MSE_ASSERT_NEXT(a_ready_after_reset, clock, 1'b0, reset, req_ready)
endmodule
bind merge_sort_engine mse_checker u_checker (.*);
`default_nettype wire
